// ===== sv/sha256_pkg.sv =====
package sha256_pkg;

  typedef logic [31:0] word_t;

  localparam word_t InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0] PadByte = 8'h80;

  function automatic word_t rotr(word_t x, int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== sv/sha256_message_hasher.sv =====
// Channel  | Signals                                          | Direction
// ---------+--------------------------------------------------+----------
// input    | in_valid_i, in_stall_o, data_word_i, bytes_valid_i,| into block
//          | end_of_message_i                                 |
// digest   | out_valid_o, out_stall_i, digest_word_o,         | out of block
//          | word_index_o, last_word_o                        |
//
// A word is taken while idle, then its valid bytes (up to four) merge one at a
// time into the block memory before the input opens again.
// A full block first loads the schedule ring from memory through the registered
// read port, then runs 64 rounds at one per cycle and folds into the hash.
// The end of a message adds pad bytes (at most 64) written one at a time, the
// two length words, and one or two block passes; then eight digest words leave.
// The input stalls whenever the block is not idle; an output stall holds the
// current digest word. Reset (rst_ni low) restores the initial hash at once.
module sha256_message_hasher (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [31:0] data_word_i,
  input  logic [2:0]  bytes_valid_i,
  input  logic        end_of_message_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  localparam logic [2:0] StIdle = 3'd0;
  localparam logic [2:0] StByte = 3'd1;  // merge one byte into the block
  localparam logic [2:0] StPad  = 3'd2;  // append pad bytes
  localparam logic [2:0] StLen  = 3'd3;  // write length words
  localparam logic [2:0] StComp = 3'd4;  // load the schedule ring, then 64 rounds
  localparam logic [2:0] StAdd  = 3'd5;  // fold working vars into hash
  localparam logic [2:0] StOut  = 3'd6;  // emit digest

  logic [2:0] state_q, state_d;

  // Block memory: 16 words, one write port, one registered read port.
  // A read of the word being written in the same cycle returns the new data.
  // The message schedule is copied out into a 16-word shift ring.
  sha256_pkg::word_t blk_mem [16];
  logic        mem_we;
  logic [3:0]  mem_waddr, mem_raddr;
  sha256_pkg::word_t mem_wdata, mem_rdata_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      blk_mem[mem_waddr] <= mem_wdata;
    end
    if (mem_we && (mem_waddr == mem_raddr)) begin
      mem_rdata_q <= mem_wdata;
    end else begin
      mem_rdata_q <= blk_mem[mem_raddr];
    end
  end

  // Input holding registers.
  sha256_pkg::word_t data_q, data_d;
  logic [2:0] left_q, left_d;
  logic       eom_q, eom_d;
  logic       final_q, final_d;   // this compression belongs to the finish

  logic [5:0]  fill_q, fill_d;
  logic [63:0] len_q, len_d;
  logic        pad_first_q, pad_first_d;
  logic        len_hi_q, len_hi_d;

  sha256_pkg::word_t hash_q [8];
  sha256_pkg::word_t hash_d [8];
  sha256_pkg::word_t v_q [8];
  sha256_pkg::word_t v_d [8];
  sha256_pkg::word_t wring_q [16];
  sha256_pkg::word_t wring_d [16];
  logic [6:0] rnd_q, rnd_d;
  logic [6:0] k_idx;
  logic [2:0] oidx_q, oidx_d;
  logic       ovld_q, ovld_d;

  // Byte merge: a byte at lane 0 replaces the word, otherwise OR in.
  logic [7:0]  cur_byte;
  logic [1:0]  lane;
  sha256_pkg::word_t merged;
  logic        rd_pending_q, rd_pending_d;

  assign lane = fill_q[1:0];

  always_comb begin
    case (lane)
      2'd0:    merged = {cur_byte, 24'h0};
      2'd1:    merged = mem_rdata_q | {8'h0, cur_byte, 16'h0};
      2'd2:    merged = mem_rdata_q | {16'h0, cur_byte, 8'h0};
      default: merged = mem_rdata_q | {24'h0, cur_byte};
    endcase
  end

  assign k_idx = rnd_q - 7'd17;

  // Round logic, the schedule held in a 16-word shift ring loaded from memory.
  sha256_pkg::word_t w_cur, t1, t2, s0w, s1w, wnew;
  always_comb begin
    w_cur = wring_q[0];
    s0w = sha256_pkg::rotr(wring_q[1], 7) ^ sha256_pkg::rotr(wring_q[1], 18)
        ^ (wring_q[1] >> 3);
    s1w = sha256_pkg::rotr(wring_q[14], 17) ^ sha256_pkg::rotr(wring_q[14], 19)
        ^ (wring_q[14] >> 10);
    wnew = s1w + wring_q[9] + s0w + wring_q[0];
    t1 = v_q[7] + (sha256_pkg::rotr(v_q[4], 6) ^ sha256_pkg::rotr(v_q[4], 11)
         ^ sha256_pkg::rotr(v_q[4], 25))
       + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
       + sha256_pkg::RoundK[k_idx[5:0]] + w_cur;
    t2 = (sha256_pkg::rotr(v_q[0], 2) ^ sha256_pkg::rotr(v_q[0], 13)
         ^ sha256_pkg::rotr(v_q[0], 22))
       + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));
  end

  assign in_stall_o = (state_q != StIdle);
  assign out_valid_o = ovld_q;
  assign digest_word_o = hash_q[oidx_q];
  assign word_index_o = oidx_q;
  assign last_word_o = (oidx_q == 3'd7);

  always_comb begin
    state_d = state_q;
    data_d = data_q;
    left_d = left_q;
    eom_d = eom_q;
    final_d = final_q;
    fill_d = fill_q;
    len_d = len_q;
    pad_first_d = pad_first_q;
    len_hi_d = len_hi_q;
    hash_d = hash_q;
    v_d = v_q;
    wring_d = wring_q;
    rnd_d = rnd_q;
    oidx_d = oidx_q;
    ovld_d = ovld_q;
    rd_pending_d = 1'b0;
    mem_we = 1'b0;
    mem_waddr = fill_q[5:2];
    mem_raddr = fill_q[5:2];
    mem_wdata = merged;
    cur_byte = data_q[31:24];

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          data_d = data_word_i;
          left_d = (bytes_valid_i > 3'd4) ? 3'd4 : bytes_valid_i;
          eom_d = end_of_message_i;
          pad_first_d = 1'b1;
          rd_pending_d = 1'b1;
          if (left_d != 3'd0) begin
            state_d = StByte;
          end else if (end_of_message_i) begin
            state_d = StPad;
          end
        end
      end
      StByte: begin
        // Read of the target word was issued last cycle.
        mem_we = 1'b1;
        data_d = {data_q[23:0], 8'h0};
        left_d = left_q - 3'd1;
        len_d = len_q + 64'd8;
        fill_d = fill_q + 6'd1;
        rd_pending_d = 1'b1;
        mem_raddr = fill_d[5:2];
        if (fill_q == 6'd63) begin
          final_d = 1'b0;
          state_d = StComp;
          rnd_d = 7'd0;
          v_d = hash_q;
        end else if (left_d == 3'd0) begin
          state_d = eom_q ? StPad : StIdle;
        end
      end
      StPad: begin
        cur_byte = pad_first_q ? sha256_pkg::PadByte : 8'h00;
        mem_we = 1'b1;
        pad_first_d = 1'b0;
        fill_d = fill_q + 6'd1;
        mem_raddr = fill_d[5:2];
        if (fill_q == 6'd63) begin
          final_d = 1'b0;
          state_d = StComp;
          rnd_d = 7'd0;
          v_d = hash_q;
        end else if (fill_d == 6'd56) begin
          len_hi_d = 1'b1;
          state_d = StLen;
        end
      end
      StLen: begin
        mem_we = 1'b1;
        mem_waddr = len_hi_q ? 4'd14 : 4'd15;
        mem_wdata = len_hi_q ? len_q[63:32] : len_q[31:0];
        len_hi_d = 1'b0;
        if (!len_hi_q) begin
          final_d = 1'b1;
          fill_d = 6'd0;
          state_d = StComp;
          rnd_d = 7'd0;
          v_d = hash_q;
        end
      end
      StComp: begin
        // The block first streams from memory into the ring through the registered
        // read port; rounds start once the ring is primed.
        if (rnd_q < 7'd17) begin
          mem_raddr = rnd_q[3:0];
          if (rnd_q != 7'd0) begin
            wring_d[rnd_q[3:0] - 4'd1] = mem_rdata_q;
          end
          rnd_d = rnd_q + 7'd1;
        end else begin
          v_d[7] = v_q[6];
          v_d[6] = v_q[5];
          v_d[5] = v_q[4];
          v_d[4] = v_q[3] + t1;
          v_d[3] = v_q[2];
          v_d[2] = v_q[1];
          v_d[1] = v_q[0];
          v_d[0] = t1 + t2;
          for (int i = 0; i < 15; i++) begin
            wring_d[i] = wring_q[i + 1];
          end
          wring_d[15] = wnew;
          rnd_d = rnd_q + 7'd1;
          if (rnd_q == 7'd80) begin
            state_d = StAdd;
          end
        end
      end
      StAdd: begin
        for (int i = 0; i < 8; i++) begin
          hash_d[i] = hash_q[i] + v_q[i];
        end
        if (final_q) begin
          state_d = StOut;
          oidx_d = 3'd0;
          ovld_d = 1'b1;
        end else begin
          mem_raddr = fill_q[5:2];
          rd_pending_d = 1'b1;
          if (left_q != 3'd0) begin
            state_d = StByte;
          end else if (eom_q) begin
            state_d = StPad;
          end else begin
            state_d = StIdle;
          end
        end
      end
      StOut: begin
        if (!out_stall_i) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == 3'd7) begin
            ovld_d = 1'b0;
            state_d = StIdle;
            hash_d = sha256_pkg::InitHash;
            len_d = 64'd0;
            fill_d = 6'd0;
            eom_d = 1'b0;
          end
        end
      end
      default: state_d = StIdle;
    endcase
  end

  // The round loop runs rnd 17..80: that is 64 rounds.
  // Round index into the constant table is rnd-17.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      left_q <= '0;
      eom_q <= 1'b0;
      final_q <= 1'b0;
      fill_q <= '0;
      len_q <= '0;
      pad_first_q <= 1'b0;
      len_hi_q <= 1'b0;
      hash_q <= sha256_pkg::InitHash;
      rnd_q <= '0;
      oidx_q <= '0;
      ovld_q <= 1'b0;
      rd_pending_q <= 1'b0;
    end else begin
      state_q <= state_d;
      left_q <= left_d;
      eom_q <= eom_d;
      final_q <= final_d;
      fill_q <= fill_d;
      len_q <= len_d;
      pad_first_q <= pad_first_d;
      len_hi_q <= len_hi_d;
      hash_q <= hash_d;
      rnd_q <= rnd_d;
      oidx_q <= oidx_d;
      ovld_q <= ovld_d;
      rd_pending_q <= rd_pending_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
    v_q <= v_d;
    wring_q <= wring_d;
  end

  // A byte merge always follows a cycle that fetched its word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StByte |-> rd_pending_q)
    else $error("byte merge without prior read");

  // Digest words are only offered while emitting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> state_q == StOut)
    else $error("output valid outside emit state");

  // The length is written exactly at fill 56.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(state_q == StLen) |-> fill_q == 6'd56)
    else $error("length written at wrong fill");

endmodule
